// ===== sv/ktt_pkg.sv =====
// ----------------------------------------------------------------------------
// ktt_pkg
// Shared types and constants of the keepalive timeout table.
// ----------------------------------------------------------------------------
package ktt_pkg;

  localparam int KEY_W   = 48;
  localparam int CNT_W   = 9;
  localparam int LIMIT_W = 8;

  localparam logic OP_KEEPALIVE = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  localparam logic KIND_TIMEOUT = 1'b0;
  localparam logic KIND_FULL    = 1'b1;

  localparam logic [CNT_W-1:0]   CNT_MAX     = 9'd511;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [KEY_W-1:0] key;
    logic             last;
  } res_push_t;

endpackage

// ===== sv/ktt_if.sv =====
// ----------------------------------------------------------------------------
// ktt_if
// Channel interfaces: input item, result item and configuration write.
// ----------------------------------------------------------------------------
interface ktt_item_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [ktt_pkg::KEY_W-1:0] node_key;

  modport source (output valid, output op, output node_key, input ready);
  modport sink   (input valid, input op, input node_key, output ready);
endinterface

interface ktt_res_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [ktt_pkg::KEY_W-1:0] node_key_res;
  logic                     last;

  modport source (output valid, output kind, output node_key_res, output last, input ready);
  modport sink   (input valid, input kind, input node_key_res, input last, output ready);
endinterface

interface ktt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ktt_pkg::LIMIT_W-1:0] timeout_limit;

  modport source (output valid, output timeout_limit, input ready);
  modport sink   (input valid, input timeout_limit, output ready);
endinterface

// ===== sv/keepalive_timeout_table_top.sv =====
// ----------------------------------------------------------------------------
// keepalive_timeout_table_top
// Heartbeat timeout monitor: keeps node keys with missed-tick counts in RAM,
// clears or inserts on keepalive, ages and expires entries on tick.
//
//   channel  dir  payload                      transaction
//   item     in   op, node_key                 valid && ready
//   result   out  kind, node_key_res, last     valid && ready
//   cfg      in   timeout_limit                valid && ready (always ready)
//
// An item holds the engine from its transaction until its walk is done (one RAM
// read per slot, a step to judge the last slot, then a write back or flush);
// the next item is accepted only once the engine is back in idle.
// Result stalls lengthen a tick and a table-full keepalive.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// Result stalls hold the slot walk; item.ready is high only between items.
// ----------------------------------------------------------------------------
module keepalive_timeout_table_top #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  ktt_item_if.sink   item,
  ktt_res_if.source  result,
  ktt_cfg_if.sink    cfg
);

  logic [ktt_pkg::LIMIT_W-1:0] limit;
  logic                        eng_idle;
  logic                        out_free;
  ktt_pkg::res_push_t          push;

  logic                        out_vld;
  logic                        out_kind;
  logic [ktt_pkg::KEY_W-1:0]   out_key;
  logic                        out_last;

  assign cfg.ready  = 1'b1;
  assign item.ready = eng_idle;
  assign out_free   = !out_vld || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= ktt_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      limit <= cfg.timeout_limit;
    end
  end

  ktt_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (item.valid && item.ready),
    .op            (item.op),
    .node_key      (item.node_key),
    .timeout_limit (limit),
    .out_free      (out_free),
    .idle          (eng_idle),
    .push          (push)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (push.valid) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_kind <= push.kind;
      out_key  <= push.key;
      out_last <= push.last;
    end
  end

  assign result.valid        = out_vld;
  assign result.kind         = out_kind;
  assign result.node_key_res = out_key;
  assign result.last         = out_last;

endmodule

// ===== sv/ktt_ram.sv =====
// ----------------------------------------------------------------------------
// ktt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ktt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ktt_engine.sv =====
// ----------------------------------------------------------------------------
// ktt_engine
// Slot walker: reads each table entry from RAM, updates counts, finds keys
// and free slots, and hands results to the output register.
// ----------------------------------------------------------------------------
module ktt_engine #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          op,
  input  logic [ktt_pkg::KEY_W-1:0]     node_key,
  input  logic [ktt_pkg::LIMIT_W-1:0]   timeout_limit,
  input  logic                          out_free,
  output logic                          idle,
  output ktt_pkg::res_push_t            push
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int DATA_W = ktt_pkg::KEY_W + ktt_pkg::CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                  state;
  logic [TABLE_ENTRIES-1:0]    valid;
  logic                        op_r;
  logic [ktt_pkg::KEY_W-1:0]   key_r;
  logic [IDX_W-1:0]            rd_idx;
  logic                        rd_done;
  logic                        ev_vld;
  logic [IDX_W-1:0]            ev_idx;
  logic                        hit;
  logic [IDX_W-1:0]            hit_idx;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic                        pend_vld;
  logic [ktt_pkg::KEY_W-1:0]   pend_key;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [DATA_W-1:0]           ram_wdata;
  logic                        ram_re;
  logic [DATA_W-1:0]           ram_rdata;

  logic [ktt_pkg::KEY_W-1:0]   ev_key;
  logic [ktt_pkg::CNT_W-1:0]   ev_cnt;
  logic [ktt_pkg::CNT_W-1:0]   cnt_inc;
  logic                        ev_live;
  logic                        expired;
  logic                        stall;
  logic                        advance;

  assign ev_key  = ram_rdata[DATA_W-1:ktt_pkg::CNT_W];
  assign ev_cnt  = ram_rdata[ktt_pkg::CNT_W-1:0];
  assign cnt_inc = (ev_cnt == ktt_pkg::CNT_MAX) ? ev_cnt : ev_cnt + 1'b1;
  assign ev_live = valid[ev_idx];
  assign expired = ev_live && (cnt_inc > {1'b0, timeout_limit});
  assign stall   = (state == S_SCAN) && ev_vld && (op_r == ktt_pkg::OP_TICK)
                   && expired && pend_vld && !out_free;
  assign advance = (state == S_SCAN) && !stall;
  assign idle    = (state == S_IDLE);

  ktt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    push      = '0;
    ram_we    = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = {ev_key, cnt_inc};
    ram_re    = advance && !rd_done;
    case (state)
      S_SCAN: begin
        if (advance && ev_vld && (op_r == ktt_pkg::OP_TICK) && ev_live) begin
          ram_we = 1'b1;
          if (expired && pend_vld) begin
            push.valid = 1'b1;
            push.kind  = ktt_pkg::KIND_TIMEOUT;
            push.key   = pend_key;
            push.last  = 1'b0;
          end
        end
      end
      S_FINISH: begin
        if (op_r == ktt_pkg::OP_KEEPALIVE) begin
          if (hit) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx;
            ram_wdata = {key_r, {ktt_pkg::CNT_W{1'b0}}};
          end else if (free_found) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx;
            ram_wdata = {key_r, {ktt_pkg::CNT_W{1'b0}}};
          end else if (out_free) begin
            push.valid = 1'b1;
            push.kind  = ktt_pkg::KIND_FULL;
            push.key   = key_r;
            push.last  = 1'b1;
          end
        end else if (pend_vld && out_free) begin
          push.valid = 1'b1;
          push.kind  = ktt_pkg::KIND_TIMEOUT;
          push.key   = pend_key;
          push.last  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      ev_vld   <= 1'b0;
      rd_done  <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r       <= op;
            key_r      <= node_key;
            rd_idx     <= '0;
            rd_done    <= 1'b0;
            ev_vld     <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            pend_vld   <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (advance) begin
            if (ev_vld) begin
              if (op_r == ktt_pkg::OP_KEEPALIVE) begin
                if (ev_live && (ev_key == key_r) && !hit) begin
                  hit     <= 1'b1;
                  hit_idx <= ev_idx;
                end
                if (!ev_live && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= ev_idx;
                end
              end else if (expired) begin
                valid[ev_idx] <= 1'b0;
                pend_vld      <= 1'b1;
                pend_key      <= ev_key;
              end
            end
            if (!rd_done) begin
              ev_vld <= 1'b1;
              ev_idx <= rd_idx;
              if (rd_idx == LAST_IDX) begin
                rd_done <= 1'b1;
              end else begin
                rd_idx <= rd_idx + 1'b1;
              end
            end else begin
              ev_vld <= 1'b0;
              state  <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (op_r == ktt_pkg::OP_KEEPALIVE) begin
            if (hit) begin
              state <= S_IDLE;
            end else if (free_found) begin
              valid[free_idx] <= 1'b1;
              state           <= S_IDLE;
            end else if (out_free) begin
              state <= S_IDLE;
            end
          end else if (!pend_vld) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> out_free)
    else $error("result pushed while output register occupied");

  a_full_is_last: assert property (@(posedge clk) disable iff (rst)
    (push.valid && (push.kind == ktt_pkg::KIND_FULL)) |-> push.last)
    else $error("table-full result not marked last");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!pend_vld && !ev_vld))
    else $error("pending timeout left behind at end of transaction");

  a_stall_holds_slot: assert property (@(posedge clk) disable iff (rst)
    stall |=> (ev_vld && (ev_idx == $past(ev_idx)) && (rd_idx == $past(rd_idx))))
    else $error("slot pointer moved during stall");

endmodule
